### hw/rtl/median_filter_3x3_unit_defines.svh
// assertion macros for the 3x3 median filter unit
`ifndef MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define MF3_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger at one edge implies the condition at the next
`define MF3_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### hw/rtl/mf3_pkg.sv
// shared constants, types and sorting network table for the median filter
package mf3_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned WIDTH_BITS    = 11;
  localparam int unsigned HEIGHT_BITS   = 16;

  localparam int unsigned WIN_TAPS = 9;
  localparam int unsigned MEDIAN_TAP = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // compare-exchange network for the median of nine, lo gets the minimum
  localparam int unsigned NET_PAIRS = 19;
  localparam int unsigned NET_LO [NET_PAIRS] =
    '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int unsigned NET_HI [NET_PAIRS] =
    '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};
  // pipeline register boundaries in the network
  localparam int unsigned NET_CUT_A = 9;
  localparam int unsigned NET_CUT_B = 16;

  // front status seen by the top level
  typedef struct packed {
    logic busy;
    logic push;
  } front_stat_t;

endpackage

### hw/rtl/mf3_ram.sv
// generic simple dual-port RAM with registered read
module mf3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mf3_queue.sv
// small request queue between the front and back parts
module mf3_queue #(
  parameter int unsigned WIDTH = 73,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       empty,
  output logic                       full
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH+1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_BITS'(DEPTH));

endmodule

### hw/rtl/mf3_front.sv
// front part: raster position tracking, line stores and the 3x3 window
module mf3_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic [PIXEL_BITS-1:0]                  pixel,
  input  logic [mf3_pkg::WIDTH_BITS-1:0]         image_width,
  input  logic [mf3_pkg::HEIGHT_BITS-1:0]        image_height,
  output mf3_pkg::front_stat_t                   stat,
  output logic [mf3_pkg::WIN_TAPS*PIXEL_BITS:0]  req_data
);
  import mf3_pkg::*;

  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;
  localparam int unsigned PB = PIXEL_BITS;

  typedef logic [WIN_TAPS*PB-1:0] win_t;

  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_nxt;
  logic [COL_BITS-1:0]    col_last, col;
  logic [HEIGHT_BITS-1:0] row_last, row;
  logic [CW-1:0]          w_ext;
  logic                   produce, last;

  logic                   s1_v_r;
  logic [PB-1:0]          s1_pix_r;
  logic [COL_BITS-1:0]    s1_col_r;
  logic                   s1_produce_r;
  logic                   s1_last_r;

  logic [2*PB-1:0]        ram_rdata;
  logic [PB-1:0]          up_pix, mid_pix;
  win_t                   win_r, win_nxt;

  // effective size, out-of-range widths and heights are clamped
  always_comb begin
    w_ext = CW'(image_width);
    if (w_ext < CW'(3)) begin
      col_last = COL_BITS'(2);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      col_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_BITS'(w_ext - CW'(1));
    end
    if (image_height < HEIGHT_BITS'(3)) begin
      row_last = HEIGHT_BITS'(2);
    end else begin
      row_last = image_height - 1'b1;
    end
  end

  always_comb begin
    col     = (col_r > col_last) ? col_last : col_r;
    row     = (row_r > row_last) ? row_last : row_r;
    produce = (col >= COL_BITS'(2)) && (row >= HEIGHT_BITS'(2));
    last    = (col == col_last) && (row == row_last);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col >= col_last) begin
        col_nxt = '0;
        row_nxt = (row >= row_last) ? '0 : row + 1'b1;
      end else begin
        col_nxt = col + 1'b1;
        row_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r     <= pixel;
      s1_col_r     <= col;
      s1_produce_r <= produce;
      s1_last_r    <= last;
    end
  end

  // one entry per column holds the upper and middle rows side by side
  mf3_ram #(
    .WIDTH (2*PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata ({ram_rdata[PB-1:0], s1_pix_r}),
    .raddr (col),
    .rdata (ram_rdata)
  );

  assign up_pix  = ram_rdata[2*PB-1:PB];
  assign mid_pix = ram_rdata[PB-1:0];

  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[(r*3+0)*PB +: PB] = win_r[(r*3+1)*PB +: PB];
      win_nxt[(r*3+1)*PB +: PB] = win_r[(r*3+2)*PB +: PB];
    end
    win_nxt[2*PB +: PB] = up_pix;
    win_nxt[5*PB +: PB] = mid_pix;
    win_nxt[8*PB +: PB] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  assign stat.busy = s1_v_r;
  assign stat.push = s1_v_r && s1_produce_r;
  assign req_data  = {s1_last_r, win_nxt};

endmodule

### hw/rtl/mf3_back.sv
// back part: pipelined median-of-nine network and the result register
module mf3_back #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  req_valid,
  input  logic [mf3_pkg::WIN_TAPS*PIXEL_BITS:0] req_data,
  output logic                                  req_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [PIXEL_BITS-1:0]                 median,
  output logic                                  last
);
  import mf3_pkg::*;

  localparam int unsigned PB = PIXEL_BITS;

  typedef logic [WIN_TAPS*PB-1:0] win_t;

  function automatic win_t sort_span(input win_t v, input int unsigned first,
                                     input int unsigned stop);
    logic [PB-1:0] a, b;
    win_t          w;
    w = v;
    for (int unsigned k = 0; k < NET_PAIRS; k++) begin
      if (k >= first && k < stop) begin
        a = w[NET_LO[k]*PB +: PB];
        b = w[NET_HI[k]*PB +: PB];
        if (b < a) begin
          w[NET_LO[k]*PB +: PB] = b;
          w[NET_HI[k]*PB +: PB] = a;
        end
      end
    end
    return w;
  endfunction

  logic    adv;
  logic    sa_v_r, sb_v_r, out_v_r;
  win_t    sa_r, sb_r, sc;
  logic    sa_last_r, sb_last_r;
  logic [PB-1:0] median_r;
  logic    last_r;

  // the whole pipe holds while an untaken result sits in the output register
  assign adv     = !(out_v_r && !pop);
  assign req_pop = adv && req_valid;
  assign sc      = sort_span(sb_r, NET_CUT_B, NET_PAIRS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      sa_v_r  <= req_valid;
      sb_v_r  <= sa_v_r;
      out_v_r <= sb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r      <= sort_span(req_data[WIN_TAPS*PB-1:0], 0, NET_CUT_A);
      sa_last_r <= req_data[WIN_TAPS*PB];
      sb_r      <= sort_span(sa_r, NET_CUT_A, NET_CUT_B);
      sb_last_r <= sa_last_r;
      median_r  <= sc[MEDIAN_TAP*PB +: PB];
      last_r    <= sb_last_r;
    end
  end

  assign empty  = !out_v_r;
  assign median = median_r;
  assign last   = last_r;

endmodule

### hw/rtl/median_filter_3x3_unit.sv
// top level of the 3x3 median filter unit
// Pixels of a frame come in raster order, one per clock while full is low,
// and each interior position gives the median of its 3x3 neighbourhood, so
// a frame of W by H pixels yields (W-2) by (H-2) results with frame_last
// on the final one. A window passes the front stage register, the request
// queue, the sorting registers and the output register. The line RAM, read
// and written once per pixel, holds the two rows above the current one.
// The three-stage sorting pipe behind a four-entry request queue keeps
// taking pixels while a finished result waits to be popped; full rises
// once the queue count plus the front stage pixel reaches QUEUE_DEPTH.
// The line RAM is not cleared after reset: results begin on the third
// row, after it has been written. The user must write width and height
// over the cfg port between frames; the block does not enforce it. Sizes
// below three act as three and widths above MAX_WIDTH as MAX_WIDTH.
`include "median_filter_3x3_unit_defines.svh"

module median_filter_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [PIXEL_BITS-1:0]              in_pixel_in,
  output logic                               empty,
  input  logic                               pop,
  output logic [PIXEL_BITS-1:0]              out_median_out,
  output logic                               out_frame_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mf3_pkg::*;

  localparam int unsigned REQ_BITS = WIN_TAPS*PIXEL_BITS + 1;
  localparam int unsigned QC_BITS  = $clog2(QUEUE_DEPTH+1);

  logic [WIDTH_BITS-1:0]  image_width_r;
  logic [HEIGHT_BITS-1:0] image_height_r;

  front_stat_t         fr_stat;
  logic [REQ_BITS-1:0] req_wdata, req_rdata;
  logic [QC_BITS-1:0]  q_count;
  logic                q_empty, q_full;
  logic                bk_pop;
  logic                accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_BITS'(512);
      image_height_r <= HEIGHT_BITS'(512);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // the pixel in the front stage may still add one request
  assign full   = ((QC_BITS+1)'(q_count) + (QC_BITS+1)'(fr_stat.busy))
                  >= (QC_BITS+1)'(QUEUE_DEPTH);
  assign accept = push && !full;

  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel        (in_pixel_in),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .stat         (fr_stat),
    .req_data     (req_wdata)
  );

  mf3_queue #(
    .WIDTH (REQ_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_stat.push),
    .wdata (req_wdata),
    .pop   (bk_pop),
    .rdata (req_rdata),
    .count (q_count),
    .empty (q_empty),
    .full  (q_full)
  );

  mf3_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (!q_empty),
    .req_data  (req_rdata),
    .req_pop   (bk_pop),
    .empty     (empty),
    .pop       (pop),
    .median    (out_median_out),
    .last      (out_frame_last)
  );

  `MF3_ASSERT_ALWAYS(a_queue_no_overflow, !(q_full && fr_stat.push), "request queue overflow")
  `MF3_ASSERT_NEXT(a_accept_enters_front, accept, fr_stat.busy, "accepted pixel lost")
  `MF3_ASSERT_ALWAYS(a_pop_needs_request, !(bk_pop && q_empty), "back popped an empty queue")

endmodule
